/* rtl/core/dmc_pkg.sv */
// shared constants, register codes and control types for the direct-mapped cache hit check
package dmc_pkg;

    // fixed widths of the port fields
    localparam int ADDRESS_WIDTH       = 32;
    localparam int LINE_INDEX_OUT_BITS = 10;
    localparam int COUNT_BITS          = 32;
    localparam int OFFSET_CFG_BITS     = 5;
    localparam int INDEX_CFG_BITS      = 4;
    localparam int CFG_DATA_BITS       = 5;
    localparam int CFG_INDEX_BITS      = 2;

    // defaults of the top-level parameters
    localparam int LINE_INDEX_BITS_DEFAULT = 10;
    localparam int ADDRESS_BITS_DEFAULT    = 32;

    // queue depths between the parts
    localparam int WORK_QUEUE_DEPTH   = 2;
    localparam int RESULT_QUEUE_DEPTH = 2;

    // configuration register reset values
    localparam logic [OFFSET_CFG_BITS-1:0] OFFSET_BITS_RESET = 5'd4;
    localparam logic [INDEX_CFG_BITS-1:0]  INDEX_BITS_RESET  = 4'd6;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_OFFSET_BITS = 2'd0,
        REG_INDEX_BITS  = 2'd1
    } cfg_reg_t;

    // back part status seen by the front part
    typedef struct packed {
        logic clearing;
        logic work_pop;
    } back_ctl_t;

endpackage

/* rtl/core/dmc_ram.sv */
// generic single-write, single-read ram with registered read data
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/dmc_front.sv */
// front part: config registers, address split into line and tag, work queue
module dmc_front #(
    parameter int LINE_INDEX_BITS = dmc_pkg::LINE_INDEX_BITS_DEFAULT,
    parameter int ADDRESS_BITS    = dmc_pkg::ADDRESS_BITS_DEFAULT,
    localparam int TAG_BITS = (ADDRESS_BITS < dmc_pkg::ADDRESS_WIDTH) ?
                              ADDRESS_BITS : dmc_pkg::ADDRESS_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [dmc_pkg::ADDRESS_WIDTH-1:0]   address,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dmc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dmc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  dmc_pkg::back_ctl_t                  back_ctl,
    output logic                                work_avail,
    output logic [LINE_INDEX_BITS-1:0]          work_line,
    output logic [TAG_BITS-1:0]                 work_tag
);

    localparam int AW       = dmc_pkg::ADDRESS_WIDTH;
    localparam int WQ_DEPTH = dmc_pkg::WORK_QUEUE_DEPTH;
    localparam int WQ_PTR   = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;
    localparam int WQ_CNT   = $clog2(WQ_DEPTH + 1);
    localparam logic [WQ_PTR-1:0] WQ_LAST = WQ_PTR'(WQ_DEPTH - 1);
    localparam logic [WQ_CNT-1:0] WQ_FULL = WQ_CNT'(WQ_DEPTH);
    localparam logic [AW-1:0] ADDR_MASK = {AW{1'b1}} >> (AW - TAG_BITS);
    localparam logic [dmc_pkg::OFFSET_CFG_BITS-1:0] OFF_MAX =
        (ADDRESS_BITS > 31) ? 5'd31 : 5'(ADDRESS_BITS);
    localparam logic [dmc_pkg::INDEX_CFG_BITS-1:0] IDX_MAX =
        (LINE_INDEX_BITS > 15) ? 4'd15 : 4'(LINE_INDEX_BITS);

    logic [dmc_pkg::OFFSET_CFG_BITS-1:0] offset_reg, offset_next;
    logic [dmc_pkg::INDEX_CFG_BITS-1:0]  index_reg, index_next;

    logic [dmc_pkg::OFFSET_CFG_BITS-1:0] off_sat;
    logic [dmc_pkg::INDEX_CFG_BITS-1:0]  idx_sat;
    logic [AW-1:0] addr_use;
    logic [AW-1:0] shifted;
    logic [AW-1:0] line_mask;
    logic [AW-1:0] line_full;
    logic [AW-1:0] tag_full;

    logic [LINE_INDEX_BITS-1:0] wq_line_reg [WQ_DEPTH];
    logic [TAG_BITS-1:0]        wq_tag_reg  [WQ_DEPTH];
    logic [WQ_PTR-1:0] wq_wr_reg, wq_wr_next;
    logic [WQ_PTR-1:0] wq_rd_reg, wq_rd_next;
    logic [WQ_CNT-1:0] wq_count_reg, wq_count_next;
    logic push_ok;

    // config writes, taken in any cycle
    assign cfg_ready = 1'b1;

    always_comb
    begin
        offset_next = offset_reg;
        index_next  = index_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (dmc_pkg::cfg_reg_t'(cfg_index))
                dmc_pkg::REG_OFFSET_BITS: offset_next = cfg_data;
                dmc_pkg::REG_INDEX_BITS:  index_next  = cfg_data[dmc_pkg::INDEX_CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // address split with saturated field widths
    always_comb
    begin
        off_sat   = (offset_reg > OFF_MAX) ? OFF_MAX : offset_reg;
        idx_sat   = (index_reg > IDX_MAX) ? IDX_MAX : index_reg;
        addr_use  = address & ADDR_MASK;
        shifted   = addr_use >> off_sat;
        line_mask = ~({AW{1'b1}} << idx_sat);
        line_full = shifted & line_mask;
        tag_full  = shifted >> idx_sat;
    end

    // work queue pointers and fill level
    assign full    = back_ctl.clearing || (wq_count_reg == WQ_FULL);
    assign push_ok = push && !full;

    always_comb
    begin
        wq_wr_next    = wq_wr_reg;
        wq_rd_next    = wq_rd_reg;
        wq_count_next = wq_count_reg;
        if (push_ok)
        begin
            wq_wr_next = (wq_wr_reg == WQ_LAST) ? '0 : wq_wr_reg + 1'b1;
        end
        if (back_ctl.work_pop)
        begin
            wq_rd_next = (wq_rd_reg == WQ_LAST) ? '0 : wq_rd_reg + 1'b1;
        end
        case ({push_ok, back_ctl.work_pop})
            2'b10:   wq_count_next = wq_count_reg + 1'b1;
            2'b01:   wq_count_next = wq_count_reg - 1'b1;
            default: wq_count_next = wq_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= dmc_pkg::OFFSET_BITS_RESET;
            index_reg    <= dmc_pkg::INDEX_BITS_RESET;
            wq_wr_reg    <= '0;
            wq_rd_reg    <= '0;
            wq_count_reg <= '0;
        end
        else
        begin
            offset_reg   <= offset_next;
            index_reg    <= index_next;
            wq_wr_reg    <= wq_wr_next;
            wq_rd_reg    <= wq_rd_next;
            wq_count_reg <= wq_count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            wq_line_reg[wq_wr_reg] <= line_full[LINE_INDEX_BITS-1:0];
            wq_tag_reg[wq_wr_reg]  <= tag_full[TAG_BITS-1:0];
        end
    end

    assign work_avail = (wq_count_reg != '0);
    assign work_line  = wq_line_reg[wq_rd_reg];
    assign work_tag   = wq_tag_reg[wq_rd_reg];

endmodule

/* rtl/core/dmc_back.sv */
// back part: tag ram lookup and refill, running counters, result queue
module dmc_back #(
    parameter int LINE_INDEX_BITS = dmc_pkg::LINE_INDEX_BITS_DEFAULT,
    parameter int ADDRESS_BITS    = dmc_pkg::ADDRESS_BITS_DEFAULT,
    localparam int TAG_BITS = (ADDRESS_BITS < dmc_pkg::ADDRESS_WIDTH) ?
                              ADDRESS_BITS : dmc_pkg::ADDRESS_WIDTH
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    work_avail,
    input  logic [LINE_INDEX_BITS-1:0]              work_line,
    input  logic [TAG_BITS-1:0]                     work_tag,
    output dmc_pkg::back_ctl_t                      back_ctl,
    output logic                                    empty,
    input  logic                                    pop,
    output logic                                    hit,
    output logic [dmc_pkg::LINE_INDEX_OUT_BITS-1:0] line_index,
    output logic [dmc_pkg::COUNT_BITS-1:0]          access_count,
    output logic [dmc_pkg::COUNT_BITS-1:0]          hit_count
);

    localparam int LINE_COUNT = 1 << LINE_INDEX_BITS;
    localparam int ENTRY_BITS = TAG_BITS + 1;
    localparam int OUT_BITS   = dmc_pkg::LINE_INDEX_OUT_BITS;
    localparam int LB = (LINE_INDEX_BITS < OUT_BITS) ? LINE_INDEX_BITS : OUT_BITS;
    localparam int CW = dmc_pkg::COUNT_BITS;
    localparam int RQ_DEPTH = dmc_pkg::RESULT_QUEUE_DEPTH;
    localparam int RQ_PTR   = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
    localparam int RQ_CNT   = $clog2(RQ_DEPTH + 1);
    localparam logic [RQ_PTR-1:0] RQ_LAST = RQ_PTR'(RQ_DEPTH - 1);
    localparam logic [RQ_CNT-1:0] RQ_FULL = RQ_CNT'(RQ_DEPTH);
    localparam logic [LINE_INDEX_BITS-1:0] LINE_LAST = {LINE_INDEX_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_CMP   = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [LINE_INDEX_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [LINE_INDEX_BITS-1:0] cmp_line_reg;
    logic [TAG_BITS-1:0]        cmp_tag_reg;
    logic [CW-1:0] acc_reg, acc_next;
    logic [CW-1:0] hits_reg, hits_next;

    logic issue;
    logic cmp_hit;
    logic ram_we;
    logic [LINE_INDEX_BITS-1:0] ram_waddr;
    logic [ENTRY_BITS-1:0]      ram_wdata;
    logic [ENTRY_BITS-1:0]      ram_rdata;
    logic [OUT_BITS-1:0]        line_ext;

    logic              res_hit_reg  [RQ_DEPTH];
    logic [OUT_BITS-1:0] res_line_reg [RQ_DEPTH];
    logic [CW-1:0]     res_acc_reg  [RQ_DEPTH];
    logic [CW-1:0]     res_hits_reg [RQ_DEPTH];
    logic [RQ_PTR-1:0] res_wr_reg, res_wr_next;
    logic [RQ_PTR-1:0] res_rd_reg, res_rd_next;
    logic [RQ_CNT-1:0] res_count_reg, res_count_next;
    logic res_push;
    logic res_pop;

    // tag ram: valid bit on top of the stored tag
    dmc_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (LINE_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (work_line),
        .rdata (ram_rdata)
    );

    // lookup issue needs a queued item and room for its result
    assign issue   = (state_reg == ST_IDLE) && work_avail && (res_count_reg != RQ_FULL);
    assign cmp_hit = ram_rdata[TAG_BITS] && (ram_rdata[TAG_BITS-1:0] == cmp_tag_reg);

    assign back_ctl.clearing = (state_reg == ST_CLEAR);
    assign back_ctl.work_pop = issue;

    // ram writes: clearing pass, then refill on a miss
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cmp_line_reg;
        ram_wdata = {1'b1, cmp_tag_reg};
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_CMP)
        begin
            ram_we = !cmp_hit;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LINE_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (issue)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_IDLE;
            default: state_next = ST_CLEAR;
        endcase
    end

    // running counters
    always_comb
    begin
        acc_next  = acc_reg;
        hits_next = hits_reg;
        if (state_reg == ST_CMP)
        begin
            acc_next = acc_reg + 1'b1;
            if (cmp_hit)
            begin
                hits_next = hits_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        line_ext = '0;
        line_ext[LB-1:0] = cmp_line_reg[LB-1:0];
    end

    // result queue control
    assign res_push = (state_reg == ST_CMP);
    assign empty    = (res_count_reg == '0);
    assign res_pop  = pop && !empty;

    always_comb
    begin
        res_wr_next    = res_wr_reg;
        res_rd_next    = res_rd_reg;
        res_count_next = res_count_reg;
        if (res_push)
        begin
            res_wr_next = (res_wr_reg == RQ_LAST) ? '0 : res_wr_reg + 1'b1;
        end
        if (res_pop)
        begin
            res_rd_next = (res_rd_reg == RQ_LAST) ? '0 : res_rd_reg + 1'b1;
        end
        case ({res_push, res_pop})
            2'b10:   res_count_next = res_count_reg + 1'b1;
            2'b01:   res_count_next = res_count_reg - 1'b1;
            default: res_count_next = res_count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            acc_reg       <= '0;
            hits_reg      <= '0;
            res_wr_reg    <= '0;
            res_rd_reg    <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            acc_reg       <= acc_next;
            hits_reg      <= hits_next;
            res_wr_reg    <= res_wr_next;
            res_rd_reg    <= res_rd_next;
            res_count_reg <= res_count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cmp_line_reg <= work_line;
            cmp_tag_reg  <= work_tag;
        end
        if (res_push)
        begin
            res_hit_reg[res_wr_reg]  <= cmp_hit;
            res_line_reg[res_wr_reg] <= line_ext;
            res_acc_reg[res_wr_reg]  <= acc_next;
            res_hits_reg[res_wr_reg] <= hits_next;
        end
    end

    assign hit          = res_hit_reg[res_rd_reg];
    assign line_index   = res_line_reg[res_rd_reg];
    assign access_count = res_acc_reg[res_rd_reg];
    assign hit_count    = res_hits_reg[res_rd_reg];

`ifndef NO_ASSERTIONS
    // a result never lands in a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_count_reg != RQ_FULL))
        else $error("result queue overflow");

    // work is taken only from the idle state
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        back_ctl.work_pop |-> (state_reg == ST_IDLE))
        else $error("work popped outside idle");

    // the compare state always goes straight back to idle
    a_cmp_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |=> (state_reg == ST_IDLE))
        else $error("compare state held");

    // a hit never rewrites its line
    a_hit_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CMP) && cmp_hit) |-> !ram_we)
        else $error("ram written on hit");

    // the access count moves by one per finished lookup
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |=> (acc_reg == $past(acc_reg) + 1'b1))
        else $error("access count step");
`endif

endmodule

/* rtl/core/direct_mapped_cache_hit_check.sv */
// top level of the direct-mapped cache hit check
// Each pushed byte address is split into offset, line index and tag by the offset_bits and
// index_bits registers and looked up in a tag ram of 2^LINE_INDEX_BITS lines; a miss refills the
// line. Results come out in order with the hit flag, line index and wrapping access and hit counts.
// A lookup in the back part is a registered tag ram read, then the compare and refill write on
// the same port pair, so the back part takes no new address until the compare of the last one is
// done, and a lookup also waits for room in the result queue. After reset a clearing pass zeroes the
// valid bits of all 2^LINE_INDEX_BITS lines (1024 at the default), with full held high;
// config writes are taken at any time and should be made only while the block is idle.
module direct_mapped_cache_hit_check #(
    parameter int LINE_INDEX_BITS = dmc_pkg::LINE_INDEX_BITS_DEFAULT,
    parameter int ADDRESS_BITS    = dmc_pkg::ADDRESS_BITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic [dmc_pkg::ADDRESS_WIDTH-1:0]       address,
    output logic                                    empty,
    input  logic                                    pop,
    output logic                                    hit,
    output logic [dmc_pkg::LINE_INDEX_OUT_BITS-1:0] line_index,
    output logic [dmc_pkg::COUNT_BITS-1:0]          access_count,
    output logic [dmc_pkg::COUNT_BITS-1:0]          hit_count,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [dmc_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [dmc_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

    localparam int TAG_BITS = (ADDRESS_BITS < dmc_pkg::ADDRESS_WIDTH) ?
                              ADDRESS_BITS : dmc_pkg::ADDRESS_WIDTH;

    dmc_pkg::back_ctl_t         back_ctl;
    logic                       work_avail;
    logic [LINE_INDEX_BITS-1:0] work_line;
    logic [TAG_BITS-1:0]        work_tag;

    // request intake and address split
    dmc_front #(
        .LINE_INDEX_BITS (LINE_INDEX_BITS),
        .ADDRESS_BITS    (ADDRESS_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .address    (address),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .back_ctl   (back_ctl),
        .work_avail (work_avail),
        .work_line  (work_line),
        .work_tag   (work_tag)
    );

    // lookup, refill and result delivery
    dmc_back #(
        .LINE_INDEX_BITS (LINE_INDEX_BITS),
        .ADDRESS_BITS    (ADDRESS_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .work_avail   (work_avail),
        .work_line    (work_line),
        .work_tag     (work_tag),
        .back_ctl     (back_ctl),
        .empty        (empty),
        .pop          (pop),
        .hit          (hit),
        .line_index   (line_index),
        .access_count (access_count),
        .hit_count    (hit_count)
    );

endmodule

/* test/tb_top.sv */
// testbench for the direct-mapped cache hit check: directed and random address traces
module tb_top;

    import dmc_pkg::*;

    localparam int LINE_BITS  = LINE_INDEX_BITS_DEFAULT;
    localparam int ADDR_BITS  = ADDRESS_BITS_DEFAULT;
    localparam int LINE_TOTAL = 1 << LINE_BITS;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int PHASE_COUNT   = 8;

    // register indexes that decode to no register
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic                           hit;
        logic [LINE_INDEX_OUT_BITS-1:0] line_index;
        logic [COUNT_BITS-1:0]          access_count;
        logic [COUNT_BITS-1:0]          hit_count;
    } lookup_t;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
    } reg_write_t;

    // tag store model and queue of lookups still owed by the block
    class lookup_tracker;
        logic [OFFSET_CFG_BITS-1:0] offset_cfg;
        logic [INDEX_CFG_BITS-1:0]  index_cfg;
        logic [63:0]                tag_store [LINE_TOTAL];
        bit                         line_valid [LINE_TOTAL];
        logic [COUNT_BITS-1:0]      accesses;
        logic [COUNT_BITS-1:0]      hits;
        lookup_t                    pending_lookups [$];
        int                         failures;
        int                         checked;
        int                         hits_seen;

        function new();
            offset_cfg = OFFSET_BITS_RESET;
            index_cfg  = INDEX_BITS_RESET;
            foreach (line_valid[i])
            begin
                line_valid[i] = 1'b0;
                tag_store[i]  = '0;
            end
            accesses  = '0;
            hits      = '0;
            failures  = 0;
            checked   = 0;
            hits_seen = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            failures++;
        endtask

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_OFFSET_BITS)
                offset_cfg = data;
            else if (idx == REG_INDEX_BITS)
                index_cfg = data[INDEX_CFG_BITS-1:0];
        endfunction

        // look the address up and refill on a miss
        function void note_address(logic [ADDRESS_WIDTH-1:0] addr);
            int unsigned off_w;
            int unsigned idx_w;
            logic [63:0] wide;
            logic [63:0] line_wide;
            logic [63:0] tag;
            logic [LINE_BITS-1:0] line;
            lookup_t e;
            off_w = 32'(offset_cfg);
            if (off_w > ADDR_BITS)
                off_w = ADDR_BITS;
            idx_w = 32'(index_cfg);
            if (idx_w > LINE_BITS)
                idx_w = LINE_BITS;
            wide      = {32'd0, addr};
            line_wide = (wide >> off_w) & ((64'd1 << idx_w) - 64'd1);
            line      = line_wide[LINE_BITS-1:0];
            tag       = wide >> (off_w + idx_w);
            e.hit = line_valid[line] && (tag_store[line] == tag);
            if (!e.hit)
            begin
                line_valid[line] = 1'b1;
                tag_store[line]  = tag;
            end
            accesses = accesses + 1'b1;
            if (e.hit)
                hits = hits + 1'b1;
            e.line_index   = line_wide[LINE_INDEX_OUT_BITS-1:0];
            e.access_count = accesses;
            e.hit_count    = hits;
            pending_lookups.push_back(e);
        endfunction

        task check_result(logic h, logic [LINE_INDEX_OUT_BITS-1:0] li,
                          logic [COUNT_BITS-1:0] ac, logic [COUNT_BITS-1:0] hc);
            lookup_t e;
            if (pending_lookups.size() == 0)
            begin
                report($sformatf("result with no lookup pending, line %0d", li));
                return;
            end
            e = pending_lookups.pop_front();
            checked++;
            if (e.hit)
                hits_seen++;
            if (h !== e.hit)
                report($sformatf("access %0d hit %b, want %b", e.access_count, h, e.hit));
            if (li !== e.line_index)
                report($sformatf("access %0d line %0d, want %0d", e.access_count, li,
                                 e.line_index));
            if (ac !== e.access_count)
                report($sformatf("access count %0d, want %0d", ac, e.access_count));
            if (hc !== e.hit_count)
                report($sformatf("access %0d hit count %0d, want %0d", e.access_count, hc,
                                 e.hit_count));
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [ADDRESS_WIDTH-1:0]       address = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic                           hit;
    logic [LINE_INDEX_OUT_BITS-1:0] line_index;
    logic [COUNT_BITS-1:0]          access_count;
    logic [COUNT_BITS-1:0]          hit_count;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [CFG_INDEX_BITS-1:0]      cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]       cfg_data = '0;

    lookup_tracker            tracker = new();
    bit                       calm = 1'b0;
    int unsigned              cur_off = 32'(OFFSET_BITS_RESET);
    int                       settings_used = 1;
    logic [ADDRESS_WIDTH-1:0] addr_pool [$];

    direct_mapped_cache_hit_check u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .address      (address),
        .empty        (empty),
        .pop          (pop),
        .hit          (hit),
        .line_index   (line_index),
        .access_count (access_count),
        .hit_count    (hit_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // push one address request and wait for it to be taken
    task automatic send_address(input logic [ADDRESS_WIDTH-1:0] a);
        push    <= 1'b1;
        address <= a;
        do
            @(posedge clk);
        while (full);
        tracker.note_address(a);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // stop pushing and let every owed result come out
    task automatic drain_lookups();
        push <= 1'b0;
        while (tracker.pending_lookups.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input reg_write_t writes [$]);
        foreach (writes[k])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= writes[k].idx;
            cfg_data  <= writes[k].data;
            do
                @(posedge clk);
            while (!cfg_ready);
            tracker.set_register(writes[k].idx, writes[k].data);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_DATA_BITS-1:0] off,
                                 input logic [CFG_DATA_BITS-1:0] idx, input bit with_spare);
        reg_write_t writes [$];
        writes.push_back('{idx: REG_OFFSET_BITS, data: off});
        if (with_spare)
            writes.push_back('{idx: ($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO),
                               data: CFG_DATA_BITS'($urandom)});
        writes.push_back('{idx: REG_INDEX_BITS, data: idx});
        write_regs(writes);
        cur_off = 32'(off);
        settings_used++;
    endtask

    // mostly reuse recent addresses so lines hit, conflict and refill
    function automatic logic [ADDRESS_WIDTH-1:0] next_address();
        logic [ADDRESS_WIDTH-1:0] a;
        logic [63:0] off_mask;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (addr_pool.size() == 0 || pick >= 7)
        begin
            a = $urandom;
            addr_pool.push_back(a);
            if (addr_pool.size() > 8)
                void'(addr_pool.pop_front());
        end
        else
        begin
            a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
            off_mask = (64'd1 << cur_off) - 64'd1;
            if (pick < 5)
                a = a ^ (ADDRESS_WIDTH'($urandom) & off_mask[ADDRESS_WIDTH-1:0]);
            else
                a = a ^ (32'd1 << $urandom_range(0, 11));
        end
        return a;
    endfunction

    // result side: pop with random stall bursts
    initial
    begin
        int idle_left;
        idle_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                tracker.check_result(hit, line_index, access_count, hit_count);
            if (idle_left > 0)
            begin
                idle_left--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                idle_left = $urandom_range(1, 9) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // stimulus
    initial
    begin
        logic [CFG_DATA_BITS-1:0] off;
        logic [CFG_DATA_BITS-1:0] idx;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: offset, refill, conflict and extreme addresses
        send_address(32'h0000_0000);
        send_address(32'h0000_0000);
        send_address(32'h0000_000F);
        send_address(32'h0000_0010);
        send_address(32'h0000_0400);
        send_address(32'h0000_0000);
        send_address(32'hFFFF_FFFF);
        send_address(32'hFFFF_FFF0);
        send_address(32'h8000_0000);
        send_address(32'h7FFF_FFFF);
        drain_lookups();

        // zero widths: one line, whole address is the tag
        apply_setting(5'd0, 5'd0, 1'b0);
        send_address(32'h0000_0000);
        send_address(32'h0000_0000);
        send_address(32'h0000_0001);
        send_address(32'hFFFF_FFFF);
        send_address(32'hFFFF_FFFF);
        drain_lookups();

        // widest offset, index saturates, fields run past the address
        apply_setting(5'd31, 5'd15, 1'b0);
        send_address(32'h8000_0000);
        send_address(32'h0000_0000);
        send_address(32'h7FFF_FFFF);
        send_address(32'hFFFF_FFFF);
        drain_lookups();

        // spare register indexes change nothing; full index width
        apply_setting(5'd16, 5'd10, 1'b1);
        send_address(32'h1234_5678);
        send_address(32'h1234_5678);
        send_address(32'hABCD_5678);
        drain_lookups();

        // back to the reset setting with no flush, index data with its top bit set
        apply_setting(5'd4, 5'd22, 1'b0);
        send_address(32'hFFFF_FFF0);
        send_address(32'h7FFF_FFF0);
        drain_lookups();

        // random traces, one register setting per phase
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    off = 5'd0;
                    idx = 5'd0;
                end
                1:
                begin
                    off = 5'd31;
                    idx = 5'd31;
                end
                2:
                begin
                    off = 5'd16;
                    idx = 5'd10;
                end
                3:
                begin
                    off = 5'd4;
                    idx = 5'd6;
                end
                default:
                begin
                    off = CFG_DATA_BITS'($urandom_range(0, 1) ? $urandom_range(0, 31) :
                                                                $urandom_range(0, 8));
                    idx = CFG_DATA_BITS'($urandom_range(0, 31));
                end
            endcase
            apply_setting(off, idx, $urandom_range(0, 3) == 0);
            calm = (p == PHASE_COUNT - 1);
            addr_pool.delete();
            repeat (PHASE_ITEMS) send_address(next_address());
            drain_lookups();
        end

        $display("checked %0d lookups (%0d hits) over %0d register settings",
                 tracker.checked, tracker.hits_seen, settings_used);
        if (tracker.failures == 0)
            $display("direct_mapped_cache_hit_check test passed");
        else
            $display("direct_mapped_cache_hit_check test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #400000;
        $display("timeout with %0d lookups pending", tracker.pending_lookups.size());
        $display("direct_mapped_cache_hit_check test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/dmc_pkg.sv
rtl/core/dmc_ram.sv
rtl/core/dmc_front.sv
rtl/core/dmc_back.sv
rtl/core/direct_mapped_cache_hit_check.sv
test/tb_top.sv
